@@ hw/rtl/ciavcs_pkg.sv @@
// ----------------------------------------------------------------------------
// ciavcs_pkg
// Shared widths, controlword codes, statusword bits and register indexes for
// the CiA 402 velocity command supervisor.
// ----------------------------------------------------------------------------
package ciavcs_pkg;

    // Field widths
    localparam int unsigned WordW  = 16;
    localparam int unsigned DzW    = 15;
    localparam int unsigned FsW    = 15;
    localparam int unsigned PerW   = 8;
    localparam int unsigned ThrW   = 12;
    localparam int unsigned ToW    = 12;
    localparam int unsigned CfgAW  = 3;
    localparam int unsigned CfgDW  = 15;
    localparam int unsigned InDW   = 32;
    localparam int unsigned OutDW  = 32;
    localparam int unsigned OutUW  = 3;

    // Controlword codes
    localparam logic [WordW-1:0] CW_PREPARE     = 16'h0006;
    localparam logic [WordW-1:0] CW_SWITCH_ON   = 16'h0007;
    localparam logic [WordW-1:0] CW_ENABLE_OP   = 16'h001F;
    localparam logic [WordW-1:0] CW_DISABLE_V   = 16'h0000;
    localparam logic [WordW-1:0] CW_FAULT_ACK   = 16'h0080;

    // Statusword bit positions
    localparam int unsigned SB_READY = 0;
    localparam int unsigned SB_ON    = 1;
    localparam int unsigned SB_OPEN  = 2;
    localparam int unsigned SB_FAULT = 3;
    localparam int unsigned SB_DISAB = 6;

    // Register reset values
    localparam logic [DzW-1:0]  DEADZONE_RST  = 15'd3000;
    localparam logic [FsW-1:0]  FULLSCALE_RST = 15'd2000;
    localparam logic [PerW-1:0] PERIOD_RST    = 8'd25;
    localparam logic [ThrW-1:0] THRESH_RST    = 12'd50;
    localparam logic [ToW-1:0]  TIMEOUT_RST   = 12'd1000;

    // Configuration register indexes
    typedef enum logic [CfgAW-1:0] {
        REG_DEADZONE   = 3'd0,
        REG_FULL_SCALE = 3'd1,
        REG_PERIOD     = 3'd2,
        REG_THRESHOLD  = 3'd3,
        REG_TIMEOUT    = 3'd4
    } cfg_index_t;

endpackage

@@ hw/rtl/cia402_velocity_command_supervisor_unit.sv @@
// ----------------------------------------------------------------------------
// cia402_velocity_command_supervisor_unit
// Drives the CiA 402 enable sequence, watches for faults and timeouts, and
// turns joystick samples into thresholded velocity targets.
// ----------------------------------------------------------------------------
// An accepted input is held in the input register and its result in the
// result register. One item per cycle while m_tready does not stall the
// result stream. The path from the input register through the scaling
// multiplier and change compare into the state and result registers sets
// the cycle. Reset is synchronous, active low: state and valids clear,
// configuration returns to its default values.
module cia402_velocity_command_supervisor_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [ciavcs_pkg::CfgAW-1:0]    cfg_addr,
    input  logic [ciavcs_pkg::CfgDW-1:0]    cfg_wdata,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ciavcs_pkg::InDW-1:0]     s_tdata,  // [15:0] status_word, [31:16] joy_sample
    input  logic [0:0]                      s_tuser,  // [0] shutdown_request
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ciavcs_pkg::OutDW-1:0]    m_tdata,  // [15:0] control_word, [31:16] vel_cmd
    output logic [ciavcs_pkg::OutUW-1:0]    m_tuser   // [0] drive_enabled, [1] disable_reached,
                                                      // [2] timeout_pulse
);
    import ciavcs_pkg::*;

    // Configuration registers
    logic [DzW-1:0]  deadzone_reg;
    logic [FsW-1:0]  full_scale_reg;
    logic [PerW-1:0] period_reg;
    logic [ThrW-1:0] thresh_reg;
    logic [ToW-1:0]  timeout_reg;

    // Input stage
    logic               in_valid_reg;
    logic [WordW-1:0]   sw_reg;
    logic signed [WordW-1:0] joy_reg;
    logic               shut_reg;

    // Supervisor state
    logic               enabled_reg,   enabled_next;
    logic [ToW-1:0]     wait_cnt_reg,  wait_cnt_next;
    logic [PerW-1:0]    upd_cnt_reg,   upd_cnt_next;
    logic signed [WordW-1:0] last_vel_reg, last_vel_next;
    logic [WordW-1:0]   held_cw_reg,   held_cw_next;
    logic signed [WordW-1:0] held_vel_reg, held_vel_next;

    // Result stage
    logic               out_valid_reg;
    logic [WordW-1:0]   out_cw_reg,    out_cw_next;
    logic [OutUW-1:0]   out_flags_reg, out_flags_next;

    logic advance;
    logic step;

    // Velocity scaling
    logic [WordW-1:0]   mag;
    logic [30:0]        prod;
    logic [15:0]        hi_part;
    logic [16:0]        fold;
    logic [15:0]        q_pos;
    logic [15:0]        q_mag;
    logic signed [WordW-1:0] vel;
    logic signed [17:0] delta;
    logic [17:0]        abs_delta;
    logic [PerW-1:0]    upd_inc;
    logic               reached;
    logic               pulse;
    logic               done;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Scale |j| * full_scale by 1/32767 (positive) or 1/32768 (negative)
    always_comb begin
        mag     = joy_reg[WordW-1] ? 16'(-joy_reg) : 16'(joy_reg);
        prod    = 31'(mag) * 31'(full_scale_reg);
        hi_part = prod[30:15];
        fold    = 17'(hi_part) + 17'(prod[14:0]);
        if (fold >= 17'd65534) begin
            q_pos = hi_part + 16'd2;
        end else if (fold >= 17'd32767) begin
            q_pos = hi_part + 16'd1;
        end else begin
            q_pos = hi_part;
        end
        q_mag = joy_reg[WordW-1] ? hi_part : q_pos;
        if (mag < 16'(deadzone_reg)) begin
            vel = '0;
        end else if (joy_reg[WordW-1]) begin
            vel = -$signed(q_mag);
        end else begin
            vel = $signed(q_mag);
        end
        delta     = 18'(vel) - 18'(last_vel_reg);
        abs_delta = delta[17] ? 18'(-delta) : 18'(delta);
    end

    // Next state and result for the item in the input register
    always_comb begin
        enabled_next  = enabled_reg;
        wait_cnt_next = wait_cnt_reg;
        upd_cnt_next  = upd_cnt_reg;
        last_vel_next = last_vel_reg;
        held_cw_next  = held_cw_reg;
        held_vel_next = held_vel_reg;
        reached       = 1'b0;
        pulse         = 1'b0;
        done          = 1'b0;
        upd_inc       = upd_cnt_reg + 8'd1;
        out_cw_next   = held_cw_reg;

        if (shut_reg) begin
            // Step toward switch on disabled with zero velocity
            held_vel_next = '0;
            last_vel_next = '0;
            enabled_next  = 1'b0;
            wait_cnt_next = '0;
            upd_cnt_next  = '0;
            if (sw_reg == '0 || sw_reg[SB_FAULT]) begin
                held_cw_next = CW_FAULT_ACK;
            end else if (sw_reg[SB_OPEN]) begin
                held_cw_next = CW_SWITCH_ON;
            end else if (sw_reg[SB_ON]) begin
                held_cw_next = CW_PREPARE;
            end else if (sw_reg[SB_READY]) begin
                held_cw_next = CW_DISABLE_V;
            end else begin
                reached = 1'b1;
            end
            out_cw_next = held_cw_next;
        end else if (!enabled_reg) begin
            // Walk the enable sequence
            if (sw_reg == '0 || sw_reg[SB_FAULT]) begin
                held_cw_next = CW_FAULT_ACK;
            end else if (sw_reg[SB_DISAB] || !sw_reg[SB_READY]) begin
                held_cw_next = CW_PREPARE;
            end else if (!sw_reg[SB_ON]) begin
                held_cw_next = CW_SWITCH_ON;
            end else if (!sw_reg[SB_OPEN]) begin
                held_cw_next = CW_ENABLE_OP;
            end else begin
                done = 1'b1;
            end
            out_cw_next = held_cw_next;
            if (done) begin
                enabled_next  = 1'b1;
                held_vel_next = '0;
                last_vel_next = '0;
                wait_cnt_next = '0;
                upd_cnt_next  = '0;
            end else if (wait_cnt_reg >= timeout_reg) begin
                pulse         = 1'b1;
                out_cw_next   = CW_FAULT_ACK;
                held_cw_next  = CW_DISABLE_V;
                wait_cnt_next = '0;
            end else begin
                wait_cnt_next = wait_cnt_reg + 12'd1;
            end
        end else begin
            // Enabled: once per update period, refresh velocity past threshold or act on fault
            upd_cnt_next = upd_inc;
            if (upd_inc >= period_reg) begin
                upd_cnt_next = '0;
                if (!sw_reg[SB_FAULT]) begin
                    if (abs_delta > 18'(thresh_reg)) begin
                        held_vel_next = vel;
                        last_vel_next = vel;
                    end
                end else begin
                    held_vel_next = '0;
                    held_cw_next  = CW_FAULT_ACK;
                    last_vel_next = '0;
                end
            end
            out_cw_next = held_cw_next;
        end
        out_flags_next = {pulse, reached, enabled_next};
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg   <= DEADZONE_RST;
            full_scale_reg <= FULLSCALE_RST;
            period_reg     <= PERIOD_RST;
            thresh_reg     <= THRESH_RST;
            timeout_reg    <= TIMEOUT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DEADZONE:   deadzone_reg   <= cfg_wdata[DzW-1:0];
                REG_FULL_SCALE: full_scale_reg <= cfg_wdata[FsW-1:0];
                REG_PERIOD:     period_reg     <= cfg_wdata[PerW-1:0];
                REG_THRESHOLD:  thresh_reg     <= cfg_wdata[ThrW-1:0];
                REG_TIMEOUT:    timeout_reg    <= cfg_wdata[ToW-1:0];
                default: ;
            endcase
        end
    end

    // Input register: capture on transfer, drop when consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sw_reg   <= s_tdata[15:0];
            joy_reg  <= $signed(s_tdata[31:16]);
            shut_reg <= s_tuser[0];
        end
    end

    // State and result register: advance one item per step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg   <= 1'b0;
            wait_cnt_reg  <= '0;
            upd_cnt_reg   <= '0;
            last_vel_reg  <= '0;
            held_cw_reg   <= '0;
            held_vel_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                enabled_reg   <= enabled_next;
                wait_cnt_reg  <= wait_cnt_next;
                upd_cnt_reg   <= upd_cnt_next;
                last_vel_reg  <= last_vel_next;
                held_cw_reg   <= held_cw_next;
                held_vel_reg  <= held_vel_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_cw_reg    <= out_cw_next;
            out_flags_reg <= out_flags_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {held_vel_reg, out_cw_reg};
    assign m_tuser  = out_flags_reg;

    // Checks
    a_pulse_cw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tdata[15:0] == CW_FAULT_ACK)
        else $error("timeout pulse without fault reset controlword");

    a_reached_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata[31:16] == '0)
        else $error("disable reached while enabled or moving");

    a_idle_zero_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        !enabled_reg |-> held_vel_reg == '0 && last_vel_reg == '0)
        else $error("nonzero velocity while not enabled");

    a_upd_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_cnt_reg != 8'hFF)
        else $error("update counter out of range");

    a_step_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_tvalid)
        else $error("processed item produced no result");

endmodule

@@ verif/supervisor_result_checker.sv @@
// ----------------------------------------------------------------------------
// supervisor_result_checker
// Watches the configuration port and both streams of the CiA 402 velocity
// command supervisor. It predicts one command per input transfer from its own
// copy of the drive supervision state and compares each result transfer,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module supervisor_result_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ciavcs_pkg::CfgAW-1:0]     cfg_addr,
    input  logic [ciavcs_pkg::CfgDW-1:0]     cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [ciavcs_pkg::InDW-1:0]      s_tdata,   // [15:0] status_word, [31:16] joy_sample
    input  logic [0:0]                       s_tuser,   // [0] shutdown_request
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [ciavcs_pkg::OutDW-1:0]     m_tdata,   // [15:0] control_word, [31:16] vel_cmd
    input  logic [ciavcs_pkg::OutUW-1:0]     m_tuser,   // [0] drive_enabled, [1] disable_reached,
                                                        // [2] timeout_pulse
    output int                               fail_count,
    output int                               pending_count
);
    import ciavcs_pkg::*;

    typedef struct packed {
        logic [WordW-1:0]        control_word;
        logic signed [WordW-1:0] vel_cmd;
        logic                    drive_enabled;
        logic                    disable_reached;
        logic                    timeout_pulse;
    } drive_command_t;

    // Configuration copy
    logic [DzW-1:0]  deadzone_q;
    logic [FsW-1:0]  full_scale_q;
    logic [PerW-1:0] period_q;
    logic [ThrW-1:0] threshold_q;
    logic [ToW-1:0]  timeout_q;

    // Supervision state copy
    logic                    enabled_q;
    logic [ToW-1:0]          enable_wait_q;
    logic [PerW-1:0]         update_cnt_q;
    logic signed [WordW-1:0] last_velocity_q;
    logic [WordW-1:0]        held_cw_q;
    logic signed [WordW-1:0] held_velocity_q;

    drive_command_t expected_cmds[$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    // Deadzone, then scale toward zero; negative side divides by 32768
    function automatic int scaled_velocity(input logic signed [WordW-1:0] joy);
        int j;
        int mag;
        int dz;
        int fs;
        j   = joy;
        dz  = deadzone_q;
        fs  = full_scale_q;
        mag = (j < 0) ? -j : j;
        if (mag < dz) return 0;
        if (j >= 0) return (mag * fs) / 32767;
        return -((mag * fs) / 32768);
    endfunction

    function automatic drive_command_t predict_command(input logic [WordW-1:0] sw,
                                                       input logic signed [WordW-1:0] joy,
                                                       input logic shut);
        drive_command_t cmd;
        logic done;
        int v;
        int d;
        int thr;
        cmd                 = '0;
        done                = 1'b0;
        thr                 = threshold_q;
        cmd.control_word    = held_cw_q;
        if (shut) begin
            // Step the drive down toward switch on disabled
            held_velocity_q = '0;
            last_velocity_q = '0;
            enabled_q       = 1'b0;
            enable_wait_q   = '0;
            update_cnt_q    = '0;
            if (sw == '0 || sw[SB_FAULT])
                held_cw_q = CW_FAULT_ACK;
            else if (sw[SB_OPEN])
                held_cw_q = CW_SWITCH_ON;
            else if (sw[SB_ON])
                held_cw_q = CW_PREPARE;
            else if (sw[SB_READY])
                held_cw_q = CW_DISABLE_V;
            else
                cmd.disable_reached = 1'b1;
            cmd.control_word = held_cw_q;
        end else if (!enabled_q) begin
            // Enable sequence with timeout
            if (sw == '0 || sw[SB_FAULT])
                held_cw_q = CW_FAULT_ACK;
            else if (sw[SB_DISAB] || !sw[SB_READY])
                held_cw_q = CW_PREPARE;
            else if (!sw[SB_ON])
                held_cw_q = CW_SWITCH_ON;
            else if (!sw[SB_OPEN])
                held_cw_q = CW_ENABLE_OP;
            else
                done = 1'b1;
            cmd.control_word = held_cw_q;
            if (done) begin
                enabled_q       = 1'b1;
                held_velocity_q = '0;
                last_velocity_q = '0;
                enable_wait_q   = '0;
                update_cnt_q    = '0;
            end else if (enable_wait_q >= timeout_q) begin
                cmd.timeout_pulse = 1'b1;
                cmd.control_word  = CW_FAULT_ACK;
                held_cw_q         = CW_DISABLE_V;
                enable_wait_q     = '0;
            end else begin
                enable_wait_q = enable_wait_q + 1'b1;
            end
        end else begin
            // Enabled: look at the statusword only on update steps
            update_cnt_q = update_cnt_q + 1'b1;
            if (update_cnt_q >= period_q) begin
                update_cnt_q = '0;
                if (!sw[SB_FAULT]) begin
                    v = scaled_velocity(joy);
                    d = v - int'(last_velocity_q);
                    if (d < 0) d = -d;
                    if (d > thr) begin
                        held_velocity_q = v[WordW-1:0];
                        last_velocity_q = v[WordW-1:0];
                    end
                end else begin
                    held_velocity_q = '0;
                    held_cw_q       = CW_FAULT_ACK;
                    last_velocity_q = '0;
                end
            end
            cmd.control_word = held_cw_q;
        end
        cmd.vel_cmd       = held_velocity_q;
        cmd.drive_enabled = enabled_q;
        return cmd;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        drive_command_t want;
        if (!aresetn) begin
            deadzone_q      = DEADZONE_RST;
            full_scale_q    = FULLSCALE_RST;
            period_q        = PERIOD_RST;
            threshold_q     = THRESH_RST;
            timeout_q       = TIMEOUT_RST;
            enabled_q       = 1'b0;
            enable_wait_q   = '0;
            update_cnt_q    = '0;
            last_velocity_q = '0;
            held_cw_q       = '0;
            held_velocity_q = '0;
            expected_cmds.delete();
            pending_count   = 0;
        end else begin
            // Track register writes
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DEADZONE:   deadzone_q   = cfg_wdata[DzW-1:0];
                    REG_FULL_SCALE: full_scale_q = cfg_wdata[FsW-1:0];
                    REG_PERIOD:     period_q     = cfg_wdata[PerW-1:0];
                    REG_THRESHOLD:  threshold_q  = cfg_wdata[ThrW-1:0];
                    REG_TIMEOUT:    timeout_q    = cfg_wdata[ToW-1:0];
                    default: ;
                endcase
            end
            // Predict on each input transfer
            if (s_tvalid && s_tready) begin
                expected_cmds.push_back(predict_command(s_tdata[15:0], s_tdata[31:16],
                                                        s_tuser[0]));
                pending_count++;
            end
            // Compare each result transfer against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_cmds.size() == 0) begin
                    fail_count++;
                    $display("%0t: result transfer with nothing expected, actual %h/%b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = expected_cmds.pop_front();
                    pending_count--;
                    check_field("control_word", want.control_word, m_tdata[15:0]);
                    check_field("vel_cmd", want.vel_cmd, $signed(m_tdata[31:16]));
                    check_field("drive_enabled", want.drive_enabled, m_tuser[0]);
                    check_field("disable_reached", want.disable_reached, m_tuser[1]);
                    check_field("timeout_pulse", want.timeout_pulse, m_tuser[2]);
                end
            end
        end
    end

endmodule

@@ verif/cia402_velocity_command_supervisor_unit_tb.sv @@
// ----------------------------------------------------------------------------
// cia402_velocity_command_supervisor_unit_tb
// Drives statusword, joystick and shutdown transfers into the supervisor
// under several register settings, with random gaps and stalls on both
// streams, and reports the verdict of the result checker.
// ----------------------------------------------------------------------------
module cia402_velocity_command_supervisor_unit_tb;
    import ciavcs_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int PHASES          = 8;
    localparam int LONG_HOLD       = 300;

    // Drive states as reported in the statusword
    localparam logic [WordW-1:0] ST_SW_ON_DISABLED = 16'h0001 << SB_DISAB;
    localparam logic [WordW-1:0] ST_READY          = 16'h0001 << SB_READY;
    localparam logic [WordW-1:0] ST_SWITCHED_ON    = ST_READY | (16'h0001 << SB_ON);
    localparam logic [WordW-1:0] ST_OP_ENABLED     = ST_SWITCHED_ON | (16'h0001 << SB_OPEN);
    localparam logic [WordW-1:0] ST_FAULT          = 16'h0001 << SB_FAULT;
    localparam logic [WordW-1:0] ST_STATE_BITS     = ST_OP_ENABLED | ST_FAULT |
                                                     ST_SW_ON_DISABLED;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [CfgAW-1:0]   cfg_addr;
    logic [CfgDW-1:0]   cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [InDW-1:0]    s_tdata;   // [15:0] status_word, [31:16] joy_sample
    logic [0:0]         s_tuser;   // [0] shutdown_request
    logic               m_tvalid;
    logic               m_tready;
    logic [OutDW-1:0]   m_tdata;   // [15:0] control_word, [31:16] vel_cmd
    logic [OutUW-1:0]   m_tuser;   // [0] drive_enabled, [1] disable_reached, [2] timeout_pulse

    int fail_count;
    int pending_count;
    int cycle_count;
    int shutdown_left;
    int cur_deadzone;
    bit calm;
    bit hold_req;

    cia402_velocity_command_supervisor_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    supervisor_result_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cia402_velocity_command_supervisor_unit regression: fail");
            $finish;
        end
    end

    // Idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Statusword: mostly a healthy enabled drive, some enable steps and faults
    function automatic logic [WordW-1:0] make_status();
        int r;
        logic [WordW-1:0] noise;
        r     = $urandom_range(0, 99);
        noise = WordW'($urandom()) & ~ST_STATE_BITS;
        if (r < 65) return ST_OP_ENABLED | noise;
        if (r < 70) return ST_SW_ON_DISABLED | noise;
        if (r < 75) return ST_READY | noise;
        if (r < 80) return ST_SWITCHED_ON | noise;
        if (r < 85) return ST_FAULT | WordW'($urandom());
        if (r < 88) return '0;
        return WordW'($urandom());
    endfunction

    // Joystick: random, extremes, and samples around the deadzone edge
    function automatic logic signed [WordW-1:0] make_joystick();
        int r;
        int j;
        r = $urandom_range(0, 99);
        if (r < 40) return WordW'($urandom());
        if (r < 55) begin
            case ($urandom_range(0, 5))
                0: j = -32768;
                1: j = -32767;
                2: j = 32767;
                3: j = 0;
                4: j = -1;
                default: j = 1;
            endcase
        end else begin
            j = cur_deadzone + $urandom_range(0, 8) - 4;
            if ($urandom_range(0, 1)) j = -j;
        end
        if (j > 32767) j = 32767;
        if (j < -32768) j = -32768;
        return j[WordW-1:0];
    endfunction

    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value[CfgDW-1:0];
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // Offer one transfer, hold it until accepted, then maybe idle
    task automatic send_cmd(input logic [WordW-1:0] sw, input logic signed [WordW-1:0] joy,
                            input logic shut);
        int gap;
        s_tdata  = {joy, sw};
        s_tuser  = shut;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Stop sending and wait until every predicted command has come back
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic configure(input int dz, input int fs, input int per, input int thr,
                             input int to);
        write_reg(REG_DEADZONE, dz);
        write_reg(REG_FULL_SCALE, fs);
        write_reg(REG_PERIOD, per);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_TIMEOUT, to);
        cur_deadzone = dz;
    endtask

    task automatic send_random();
        logic shut;
        if (shutdown_left == 0 && $urandom_range(0, 99) < 3)
            shutdown_left = $urandom_range(1, 6);
        shut = (shutdown_left > 0);
        if (shut) shutdown_left--;
        send_cmd(make_status(), make_joystick(), shut);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready   = 1'b1;
                stall_left = idle_len();
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int ph;
        int k;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        shutdown_left = 0;
        cur_deadzone  = DEADZONE_RST;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Enable sequence and shutdown steps under reset settings
        send_cmd('0, 16'sd0, 1'b0);                       // zero statusword
        send_cmd(ST_FAULT, 16'sd0, 1'b0);                 // fault bit
        send_cmd(ST_SW_ON_DISABLED, 16'sd0, 1'b0);
        send_cmd(16'h0010, 16'sd0, 1'b0);                 // not ready, nonzero
        send_cmd(ST_READY, 16'sd0, 1'b0);
        send_cmd(ST_SWITCHED_ON, 16'sd0, 1'b0);
        send_cmd(ST_OP_ENABLED, 16'sd0, 1'b0);            // enable reached
        send_cmd(ST_OP_ENABLED, 16'sd32767, 1'b1);
        send_cmd(ST_SWITCHED_ON, -16'sd32768, 1'b1);
        send_cmd(ST_READY, 16'sd0, 1'b1);
        send_cmd(ST_SW_ON_DISABLED, 16'sd0, 1'b1);        // disable reached
        send_cmd('0, 16'sd0, 1'b1);
        send_cmd(ST_FAULT | ST_OP_ENABLED, 16'sd0, 1'b1);
        drain();

        // Enable timeout, then scaling extremes and fault while enabled
        configure(DEADZONE_RST, FULLSCALE_RST, 1, 0, 2);
        repeat (4) send_cmd(ST_SW_ON_DISABLED, 16'sd0, 1'b0);
        send_cmd(ST_OP_ENABLED, 16'sd0, 1'b0);
        send_cmd(ST_OP_ENABLED, 16'sd32767, 1'b0);
        send_cmd(ST_OP_ENABLED, -16'sd32768, 1'b0);
        send_cmd(ST_OP_ENABLED, 16'sd2999, 1'b0);
        send_cmd(ST_OP_ENABLED, 16'sd3000, 1'b0);
        send_cmd(ST_OP_ENABLED, -16'sd3000, 1'b0);
        send_cmd('0, 16'sd0, 1'b0);                       // zero statusword while enabled
        send_cmd(ST_FAULT, 16'sd100, 1'b0);               // fault while enabled
        send_cmd(ST_OP_ENABLED, 16'sd32767, 1'b0);
        send_cmd(ST_OP_ENABLED, 16'sd0, 1'b1);

        // Random phases, each under its own settings
        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: configure(0, 32767, 1, 0, 1);
                1: configure(32767, 0, 255, 4095, 4095);
                2: configure($urandom_range(0, 4000), 32767, $urandom_range(1, 3),
                             $urandom_range(0, 60), $urandom_range(1, 6));
                default: configure($urandom_range(0, 8000), $urandom_range(0, 32767),
                                   $urandom_range(1, 6), $urandom_range(0, 400),
                                   $urandom_range(1, 12));
            endcase
            calm = (ph == 2 || ph == 6);
            if (ph == 3) hold_req = 1'b1;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 5 && k == ITEMS_PER_PHASE / 2) drain();
                send_random();
            end
        end

        drain();
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("cia402_velocity_command_supervisor_unit regression: pass");
        end else begin
            $display("cia402_velocity_command_supervisor_unit regression: fail");
        end
        $finish;
    end

endmodule
